/* hw/rtl/ctc_pkg.sv */
// Shared types, register codes and reset constants for the two-player countdown clock.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package ctc_pkg;

  localparam int unsigned TIME_BITS_DEF = 16;
  localparam int unsigned INC_W         = 14;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned CFG_IDX_W     = 3;

  typedef enum logic [1:0] {
    MODE_READY  = 2'd0,
    MODE_FIRST  = 2'd1,
    MODE_SECOND = 2'd2,
    MODE_HOLD   = 2'd3
  } ctc_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INIT_TIME  = 3'd0,
    CFG_INIT_INC   = 3'd1,
    CFG_NEXT_TIME  = 3'd2,
    CFG_NEXT_INC   = 3'd3,
    CFG_PAUSE_TIME = 3'd4,
    CFG_PAUSE_INC  = 3'd5
  } ctc_cfg_e;

  localparam logic [CFG_DATA_W-1:0] INIT_TIME_RST  = 16'd600;
  localparam logic [INC_W-1:0]      INIT_INC_RST   = 14'd10;
  localparam logic [CFG_DATA_W-1:0] NEXT_TIME_RST  = 16'd1800;
  localparam logic [INC_W-1:0]      NEXT_INC_RST   = 14'd20;
  localparam logic [CFG_DATA_W-1:0] PAUSE_TIME_RST = 16'd3000;
  localparam logic [INC_W-1:0]      PAUSE_INC_RST  = 14'd10;

  typedef struct packed {
    logic tick;
    logic first_press;
    logic second_press;
    logic next_press;
    logic pause_press;
  } ctc_item_t;

  // Advance enables of the digit pipeline stages.
  typedef struct packed {
    logic adv_a;
    logic adv_b;
    logic adv_c;
    logic adv_out;
  } ctc_adv_t;

endpackage

/* hw/rtl/ctc_core.sv */
// Input item register, preset registers and the clock state update.
// Depends on ctc_pkg.
`timescale 1ns / 1ps

module ctc_core #(
  parameter int unsigned TIME_BITS = ctc_pkg::TIME_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  input  logic [ctc_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [ctc_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                  load_i,
  input  ctc_pkg::ctc_item_t                    item_i,
  input  logic                                  step_i,
  output ctc_pkg::ctc_mode_e                    mode_o,
  output logic [TIME_BITS-1:0]                  first_time_o,
  output logic [TIME_BITS-1:0]                  second_time_o,
  output logic                                  buzz_o
);
  import ctc_pkg::*;

  localparam int unsigned XW = (TIME_BITS > CFG_DATA_W) ? TIME_BITS : CFG_DATA_W;
  localparam int unsigned SW = ((TIME_BITS > INC_W) ? TIME_BITS : INC_W) + 1;
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

  function automatic logic [TIME_BITS-1:0] cap_time(input logic [CFG_DATA_W-1:0] v);
    logic [XW-1:0] e;
    begin
      e = XW'(v);
      if (e > XW'(TMAX)) begin
        cap_time = TMAX;
      end else begin
        cap_time = TIME_BITS'(e);
      end
    end
  endfunction

  ctc_item_t              item_q;
  logic [CFG_DATA_W-1:0]  next_time_q, pause_time_q;
  logic [INC_W-1:0]       next_inc_q, pause_inc_q;
  ctc_mode_e              mode_q, mode_d;
  logic [TIME_BITS-1:0]   t1_q, t1_d, t2_q, t2_d;
  logic [INC_W-1:0]       inc_q, inc_d;
  logic                   buzz_q, buzz_d;

  logic [TIME_BITS-1:0]   cur_t, dec_t, run_t;
  logic [SW-1:0]          sum_t;
  logic                   own;
  ctc_mode_e              run_mode;
  logic                   run_buzz;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_time_q  <= NEXT_TIME_RST;
      next_inc_q   <= NEXT_INC_RST;
      pause_time_q <= PAUSE_TIME_RST;
      pause_inc_q  <= PAUSE_INC_RST;
    end else if (cfg_valid_i) begin
      case (ctc_cfg_e'(cfg_index_i))
        CFG_NEXT_TIME:  next_time_q  <= cfg_data_i;
        CFG_NEXT_INC:   next_inc_q   <= cfg_data_i[INC_W-1:0];
        CFG_PAUSE_TIME: pause_time_q <= cfg_data_i;
        CFG_PAUSE_INC:  pause_inc_q  <= cfg_data_i[INC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cur_t    = (mode_q == MODE_FIRST) ? t1_q : t2_q;
    own      = (mode_q == MODE_FIRST) ? item_q.first_press : item_q.second_press;
    dec_t    = (item_q.tick && (cur_t != '0)) ? cur_t - TIME_BITS'(1) : cur_t;
    sum_t    = SW'(dec_t) + SW'(inc_q);
    run_t    = dec_t;
    run_mode = mode_q;
    run_buzz = 1'b0;
    if (own) begin
      run_t    = (sum_t > SW'(TMAX)) ? TMAX : sum_t[TIME_BITS-1:0];
      run_mode = (mode_q == MODE_FIRST) ? MODE_SECOND : MODE_FIRST;
    end else if (dec_t == '0) begin
      run_t    = '0;
      run_mode = MODE_HOLD;
      run_buzz = 1'b1;
    end else if (item_q.pause_press) begin
      run_mode = MODE_READY;
    end
  end

  always_comb begin
    mode_d = mode_q;
    t1_d   = t1_q;
    t2_d   = t2_q;
    inc_d  = inc_q;
    buzz_d = 1'b0;
    case (mode_q)
      MODE_READY: begin
        if (item_q.first_press) begin
          mode_d = MODE_SECOND;
        end else if (item_q.second_press) begin
          mode_d = MODE_FIRST;
        end
        if (item_q.pause_press) begin
          t1_d  = cap_time(pause_time_q);
          t2_d  = cap_time(pause_time_q);
          inc_d = pause_inc_q;
        end else if (item_q.next_press) begin
          t1_d  = cap_time(next_time_q);
          t2_d  = cap_time(next_time_q);
          inc_d = next_inc_q;
        end
      end
      MODE_FIRST: begin
        t1_d   = run_t;
        mode_d = run_mode;
        buzz_d = run_buzz;
      end
      MODE_SECOND: begin
        t2_d   = run_t;
        mode_d = run_mode;
        buzz_d = run_buzz;
      end
      default: begin
        buzz_d = item_q.first_press || item_q.second_press;
        if (item_q.next_press || item_q.pause_press) begin
          mode_d = MODE_READY;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_READY;
      t1_q   <= cap_time(INIT_TIME_RST);
      t2_q   <= cap_time(INIT_TIME_RST);
      inc_q  <= INIT_INC_RST;
      buzz_q <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      t1_q   <= t1_d;
      t2_q   <= t2_d;
      inc_q  <= inc_d;
      buzz_q <= buzz_d;
    end
  end

  assign mode_o        = mode_q;
  assign first_time_o  = t1_q;
  assign second_time_o = t2_q;
  assign buzz_o        = buzz_q;

endmodule

/* hw/rtl/ctc_digits.sv */
// Pipeline that turns a remaining time in tenths into minute and second digits.
// Divides by 10, 600 and 6000 via reciprocal multiplication and one correction.
// Depends on ctc_pkg.
`timescale 1ns / 1ps

module ctc_digits #(
  parameter int unsigned TIME_BITS = ctc_pkg::TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  ctc_pkg::ctc_adv_t     adv_i,
  input  logic [TIME_BITS-1:0]  time_i,
  output logic [3:0]            min_tens_o,
  output logic [3:0]            min_ones_o,
  output logic [2:0]            sec_tens_o,
  output logic [3:0]            sec_ones_o
);
  import ctc_pkg::*;

  localparam int unsigned W  = TIME_BITS;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned CW = W + 1;
  localparam logic [W-1:0]  K10   = W'((64'd1 << W) / 10);
  localparam logic [W-1:0]  K600  = W'((64'd1 << W) / 600);
  localparam logic [W-1:0]  K6000 = W'((64'd1 << W) / 6000);
  localparam logic [CW-1:0] D10   = CW'(10);
  localparam logic [CW-1:0] D60   = CW'(60);
  localparam logic [CW-1:0] D600  = CW'(600);
  localparam logic [CW-1:0] D6000 = CW'(6000);

  logic [PW-1:0]  p10, p600, p6000, pm;
  logic [W-1:0]   t_a_q, q10_a_q, q600_a_q, q6000_a_q;
  logic [CW-1:0]  r10, r600, r6000;
  logic [CW-1:0]  s_d, m60_d, m600_d;
  logic [CW-1:0]  s_b_q, m60_b_q, m600_b_q;
  logic [CW-1:0]  r60_full, mo_full;
  logic [5:0]     r60_c_q;
  logic [3:0]     min_ones_c_q;
  logic [CW-1:0]  m600_c_q;
  logic [W-1:0]   qm_c_q;
  logic [CW-1:0]  rm, mt_full;
  logic [2:0]     st;
  logic [5:0]     so_full;

  assign p10   = PW'(time_i) * PW'(K10);
  assign p600  = PW'(time_i) * PW'(K600);
  assign p6000 = PW'(time_i) * PW'(K6000);

  always_ff @(posedge clk_i) begin
    if (adv_i.adv_a) begin
      t_a_q     <= time_i;
      q10_a_q   <= p10[PW-1:W];
      q600_a_q  <= p600[PW-1:W];
      q6000_a_q <= p6000[PW-1:W];
    end
  end

  always_comb begin
    r10    = CW'(t_a_q) - CW'(q10_a_q) * D10;
    r600   = CW'(t_a_q) - CW'(q600_a_q) * D600;
    r6000  = CW'(t_a_q) - CW'(q6000_a_q) * D6000;
    s_d    = CW'(q10_a_q)   + ((r10   >= D10)   ? CW'(1) : CW'(0));
    m60_d  = CW'(q600_a_q)  + ((r600  >= D600)  ? CW'(1) : CW'(0));
    m600_d = CW'(q6000_a_q) + ((r6000 >= D6000) ? CW'(1) : CW'(0));
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.adv_b) begin
      s_b_q    <= s_d;
      m60_b_q  <= m60_d;
      m600_b_q <= m600_d;
    end
  end

  assign r60_full = s_b_q - m60_b_q * D60;
  assign mo_full  = m60_b_q - m600_b_q * D10;
  assign pm       = PW'(m600_b_q[W-1:0]) * PW'(K10);

  always_ff @(posedge clk_i) begin
    if (adv_i.adv_c) begin
      r60_c_q      <= r60_full[5:0];
      min_ones_c_q <= mo_full[3:0];
      m600_c_q     <= m600_b_q;
      qm_c_q       <= pm[PW-1:W];
    end
  end

  always_comb begin
    rm      = m600_c_q - CW'(qm_c_q) * D10;
    mt_full = (rm >= D10) ? rm - D10 : rm;
    if (r60_c_q >= 6'd50) begin
      st = 3'd5;
    end else if (r60_c_q >= 6'd40) begin
      st = 3'd4;
    end else if (r60_c_q >= 6'd30) begin
      st = 3'd3;
    end else if (r60_c_q >= 6'd20) begin
      st = 3'd2;
    end else if (r60_c_q >= 6'd10) begin
      st = 3'd1;
    end else begin
      st = 3'd0;
    end
    so_full = r60_c_q - 6'(st) * 6'd10;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.adv_out) begin
      min_tens_o <= mt_full[3:0];
      min_ones_o <= min_ones_c_q;
      sec_tens_o <= st;
      sec_ones_o <= so_full[3:0];
    end
  end

endmodule

/* hw/rtl/two_player_countdown_clock.sv */
// Two-player countdown clock with increment: top level with pipeline control.
// The result of an item comes out with out_valid_o; one item per cycle unless stalled.
// The state update takes one stage; the digit conversion of both times takes four more.
// Each stage holds while the one after it is full and stalled, so ready needs no idle state.
// Reset loads the default presets, ready mode and the default time for both players.
// Depends on ctc_pkg, ctc_core and ctc_digits.
`timescale 1ns / 1ps

module two_player_countdown_clock #(
  parameter int unsigned TIME_BITS = ctc_pkg::TIME_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ctc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ctc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            tick_i,
  input  logic                            first_press_i,
  input  logic                            second_press_i,
  input  logic                            next_press_i,
  input  logic                            pause_press_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      mode_now_o,
  output logic [3:0]                      first_min_tens_o,
  output logic [3:0]                      first_min_ones_o,
  output logic [2:0]                      first_sec_tens_o,
  output logic [3:0]                      first_sec_ones_o,
  output logic [3:0]                      second_min_tens_o,
  output logic [3:0]                      second_min_ones_o,
  output logic [2:0]                      second_sec_tens_o,
  output logic [3:0]                      second_sec_ones_o,
  output logic                            buzz_o
);
  import ctc_pkg::*;

  localparam int unsigned NSTG = 6;

  logic [NSTG-1:0]       v_q;
  logic [NSTG-1:0]       en;
  ctc_item_t             item;
  ctc_adv_t              adv;
  ctc_mode_e             mode_s1;
  logic                  buzz_s1;
  logic [TIME_BITS-1:0]  t1_s1, t2_s1;
  ctc_mode_e             mode_p_q [4];
  logic                  buzz_p_q [4];

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || !out_stall_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign item = '{tick: tick_i, first_press: first_press_i, second_press: second_press_i,
                  next_press: next_press_i, pause_press: pause_press_i};
  assign adv  = '{adv_a: en[2], adv_b: en[3], adv_c: en[4], adv_out: en[5]};

  ctc_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .load_i        (en[0]),
    .item_i        (item),
    .step_i        (en[1] && v_q[0]),
    .mode_o        (mode_s1),
    .first_time_o  (t1_s1),
    .second_time_o (t2_s1),
    .buzz_o        (buzz_s1)
  );

  ctc_digits #(
    .TIME_BITS (TIME_BITS)
  ) u_digits_first (
    .clk_i      (clk_i),
    .adv_i      (adv),
    .time_i     (t1_s1),
    .min_tens_o (first_min_tens_o),
    .min_ones_o (first_min_ones_o),
    .sec_tens_o (first_sec_tens_o),
    .sec_ones_o (first_sec_ones_o)
  );

  ctc_digits #(
    .TIME_BITS (TIME_BITS)
  ) u_digits_second (
    .clk_i      (clk_i),
    .adv_i      (adv),
    .time_i     (t2_s1),
    .min_tens_o (second_min_tens_o),
    .min_ones_o (second_min_ones_o),
    .sec_tens_o (second_sec_tens_o),
    .sec_ones_o (second_sec_ones_o)
  );

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      mode_p_q[0] <= mode_s1;
      buzz_p_q[0] <= buzz_s1;
    end
    for (int k = 1; k < 4; k++) begin
      if (en[k+2]) begin
        mode_p_q[k] <= mode_p_q[k-1];
        buzz_p_q[k] <= buzz_p_q[k-1];
      end
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[NSTG-1];
  assign mode_now_o  = mode_p_q[3];
  assign buzz_o      = buzz_p_q[3];

endmodule

/* hw/rtl/ctc_checker.sv */
// Port-level checks for the two-player countdown clock, bound to the top level.
// Depends on ctc_pkg and two_player_countdown_clock.
`timescale 1ns / 1ps

module ctc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic [ctc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input logic [ctc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [1:0]                      mode_now_o,
  input logic [3:0]                      first_min_ones_o,
  input logic [2:0]                      first_sec_tens_o,
  input logic [3:0]                      first_sec_ones_o,
  input logic [3:0]                      second_min_ones_o,
  input logic [2:0]                      second_sec_tens_o,
  input logic [3:0]                      second_sec_ones_o,
  input logic                            buzz_o
);
  import ctc_pkg::*;

  // A buzzer start comes from a timeout or a press in hold, so the clock is held or ready.
  a_buzz_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && buzz_o) |-> (mode_now_o == MODE_HOLD || mode_now_o == MODE_READY))
    else $error("buzz with a running turn");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (first_sec_tens_o <= 3'd5 && second_sec_tens_o <= 3'd5 &&
                     first_sec_ones_o <= 4'd9 && second_sec_ones_o <= 4'd9 &&
                     first_min_ones_o <= 4'd9 && second_min_ones_o <= 4'd9))
    else $error("digit out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(mode_now_o) && $stable(buzz_o)))
    else $error("stalled result changed");

  // With an empty output stage nothing blocks the pipeline input.
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && $past(!out_valid_o) && $past(!in_valid_i, 1) && $past(!in_valid_i, 2) &&
     $past(!in_valid_i, 3) && $past(!in_valid_i, 4) && $past(!in_valid_i, 5) &&
     $past(!in_valid_i, 6)) |-> !in_stall_o)
    else $error("input stalled with an empty pipeline");

endmodule

bind two_player_countdown_clock ctc_checker u_ctc_checker (.*);
